@@ sv/quadrature_decoder_accel_core_defines.svh @@
// Assertion macros for the quadrature decoder core.
// Included by the top level; no other dependencies.
`ifndef QUADRATURE_DECODER_ACCEL_CORE_DEFINES_SVH
`define QUADRATURE_DECODER_ACCEL_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// condition checked at every clock edge outside reset
`define QDA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define QDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QDA_ASSERT(lbl, cond, msg)
`define QDA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/qdec_acc_pkg.sv @@
// Shared types and constants for the quadrature decoder core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qdec_acc_pkg;

    localparam int FACTOR_W = 7;
    localparam int WINDOW_W = 16;
    localparam int TIME_W   = 32;
    localparam int POS_W    = 32;
    localparam int MOVED_W  = 8;
    localparam int DELTA_W  = 16;

    // configuration register indexes
    localparam logic [1:0] REG_ACCEL_FACTOR = 2'd0;
    localparam logic [1:0] REG_FAST_WINDOW  = 2'd1;
    localparam logic [1:0] REG_SLOW_WINDOW  = 2'd2;

    // reset values of the configuration registers
    localparam logic [FACTOR_W-1:0] FACTOR_RST      = 7'd1;
    localparam logic [WINDOW_W-1:0] FAST_WINDOW_RST = 16'd40;
    localparam logic [WINDOW_W-1:0] SLOW_WINDOW_RST = 16'd80;

    // encoder pair codes, B in bit 1 and A in bit 0
    localparam logic [1:0] AB_BOTH_LOW  = 2'b00;
    localparam logic [1:0] AB_B_ONLY    = 2'b10;
    localparam logic [1:0] AB_A_ONLY    = 2'b01;
    localparam logic [1:0] AB_IDLE_HIGH = 2'b11;

    // item kinds
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TAKE   = 1'b1;

    typedef struct packed {
        logic [FACTOR_W-1:0] accel_factor;
        logic [WINDOW_W-1:0] fast_window_ms;
        logic [WINDOW_W-1:0] slow_window_ms;
    } cfg_t;

    typedef struct packed {
        logic              mode;
        logic              enc_a;
        logic              enc_b;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic signed [MOVED_W-1:0] moved_by;
        logic signed [POS_W-1:0]   position;
    } result_t;

endpackage

`default_nettype wire

@@ sv/qdec_acc_cfg.sv @@
// Configuration register file for the quadrature decoder core.
// Depends on qdec_acc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qdec_acc_cfg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_wdata,
    output qdec_acc_pkg::cfg_t       cfg
);
    import qdec_acc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ACCEL_FACTOR: cfg_next.accel_factor   = cfg_wdata[FACTOR_W-1:0];
                REG_FAST_WINDOW:  cfg_next.fast_window_ms = cfg_wdata[WINDOW_W-1:0];
                REG_SLOW_WINDOW:  cfg_next.slow_window_ms = cfg_wdata[WINDOW_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_factor   <= FACTOR_RST;
            cfg_reg.fast_window_ms <= FAST_WINDOW_RST;
            cfg_reg.slow_window_ms <= SLOW_WINDOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ sv/qdec_acc_update.sv @@
// Decoder state and combinational next-state update: step detection, acceleration,
// position accumulation and saturated delta. Depends on qdec_acc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qdec_acc_update (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire qdec_acc_pkg::cfg_t   cfg,
    input  wire logic                 advance,
    input  wire qdec_acc_pkg::item_t  item,
    output qdec_acc_pkg::result_t     result
);
    import qdec_acc_pkg::*;

    logic [1:0]        last_ab_reg,   last_ab_next;
    logic [TIME_W-1:0] step_time_reg, step_time_next;
    logic [POS_W-1:0]  accum_reg,     accum_next;
    logic [POS_W-1:0]  reported_reg,  reported_next;

    logic [1:0]          cur_ab;
    logic                step_up;
    logic                step_dn;
    logic [FACTOR_W-1:0] full_scale;
    logic [FACTOR_W-1:0] half_scale;
    logic [FACTOR_W-1:0] scale;
    logic [TIME_W-1:0]   gap;
    logic                in_slow;
    logic                in_fast;
    logic [MOVED_W-1:0]  moved;
    logic [POS_W-1:0]    diff;
    logic [DELTA_W-1:0]  delta_sat;

    // step detection: only a move out of both-low counts
    assign cur_ab  = {item.enc_b, item.enc_a};
    assign step_up = (last_ab_reg == AB_BOTH_LOW) && (cur_ab == AB_B_ONLY);
    assign step_dn = (last_ab_reg == AB_BOTH_LOW) && (cur_ab == AB_A_ONLY);

    // acceleration factor from the interval since the last counted step
    assign full_scale = (cfg.accel_factor == '0) ? FACTOR_W'(1) : cfg.accel_factor;
    assign half_scale = (full_scale[FACTOR_W-1:1] == '0) ? FACTOR_W'(1)
                                                         : (full_scale >> 1);
    assign gap     = item.now_ms - step_time_reg;
    assign in_slow = gap < {{(TIME_W-WINDOW_W){1'b0}}, cfg.slow_window_ms};
    assign in_fast = gap < {{(TIME_W-WINDOW_W){1'b0}}, cfg.fast_window_ms};

    always_comb
    begin
        scale = FACTOR_W'(1);
        if (in_slow)
        begin
            scale = in_fast ? full_scale : half_scale;
        end
    end

    always_comb
    begin
        moved = '0;
        if (step_up)
        begin
            moved = {1'b0, scale};
        end
        else if (step_dn)
        begin
            moved = '0 - {1'b0, scale};
        end
    end

    // saturate the 32-bit signed difference to 16 bits
    assign diff = accum_reg - reported_reg;

    always_comb
    begin
        if (!diff[POS_W-1] && (diff[POS_W-2:DELTA_W-1] != '0))
        begin
            delta_sat = {1'b0, {(DELTA_W-1){1'b1}}};
        end
        else if (diff[POS_W-1] && (diff[POS_W-2:DELTA_W-1] != '1))
        begin
            delta_sat = {1'b1, {(DELTA_W-1){1'b0}}};
        end
        else
        begin
            delta_sat = diff[DELTA_W-1:0];
        end
    end

    // next state and result of this transaction
    always_comb
    begin
        last_ab_next   = last_ab_reg;
        step_time_next = step_time_reg;
        accum_next     = accum_reg;
        reported_next  = reported_reg;
        result.position = accum_reg;
        result.moved_by = '0;
        result.delta    = '0;
        if (item.mode == MODE_SAMPLE)
        begin
            last_ab_next = cur_ab;
            if (step_up || step_dn)
            begin
                accum_next     = accum_reg + {{(POS_W-MOVED_W){moved[MOVED_W-1]}}, moved};
                step_time_next = item.now_ms;
            end
            result.position = accum_next;
            result.moved_by = moved;
        end
        else
        begin
            reported_next = accum_reg;
            result.delta  = delta_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ab_reg   <= AB_IDLE_HIGH;
            step_time_reg <= '0;
            accum_reg     <= '0;
            reported_reg  <= '0;
        end
        else if (advance)
        begin
            last_ab_reg   <= last_ab_next;
            step_time_reg <= step_time_next;
            accum_reg     <= accum_next;
            reported_reg  <= reported_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/quadrature_decoder_accel_core.sv @@
// Quadrature decoder with step acceleration.
//
// Input stream: one transaction per item. tuser is the kind (0 encoder sample,
// 1 take delta since the last take); tdata carries the A/B levels and a
// millisecond timestamp. Output stream: one transaction per input item with
// the position after the item, the scaled step it applied and, for a take,
// the change since the previous take saturated to 16 bits.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 factor,
// 1 fast window, 2 slow window) at the clock edge; write only while idle.
// Pipeline: a result passes through the input register, then the result register.
// Throughput: one item per cycle while the output accepts results; the state
// update is combinational logic between those two registers.
// Reset: asynchronous, clears position, mark and timestamp, sets the pair to
// both high and loads the register defaults (factor 1, windows 40 and 80 ms).
// Stall: while the result waits, one more item is held in the input register;
// tready then drops until the output transaction completes.
// Depends on qdec_acc_pkg, qdec_acc_cfg, qdec_acc_update and the defines header.
`timescale 1ns / 1ps
`default_nettype none

`include "quadrature_decoder_accel_core_defines.svh"

module quadrature_decoder_accel_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // enc_a, enc_b, now_ms[31:0], zero pad
    input  wire logic        s_axis_tuser,   // mode
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // position[31:0], moved_by[7:0], delta[15:0]
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import qdec_acc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result_next;
    result_t result_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_accept;

    // handshake: input register moves into the result register when free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    qdec_acc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    qdec_acc_update u_update (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .item    (item_reg),
        .result  (result_next)
    );

    // valid flags of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.mode   <= s_axis_tuser;
            item_reg.enc_a  <= s_axis_tdata[0];
            item_reg.enc_b  <= s_axis_tdata[1];
            item_reg.now_ms <= s_axis_tdata[33:2];
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {result_reg.delta, result_reg.moved_by, result_reg.position};

    // a result carries a step or a delta, never both
    `QDA_ASSERT(a_step_or_delta, !out_valid_reg || (result_reg.moved_by == '0) || (result_reg.delta == '0), "result has both step and delta")
    // scaled step never reaches -128
    `QDA_ASSERT(a_moved_range, !out_valid_reg || (result_reg.moved_by != 8'sh80), "step out of range")
    // a held item is not dropped while the output stalls
    `QDA_ASSERT_NEXT(a_hold_item, in_valid_reg && out_valid_reg && !m_axis_tready, in_valid_reg && out_valid_reg, "item lost during stall")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for quadrature_decoder_accel_core: A/B samples and take-delta
// transactions go in, and every output transaction is checked against an in-bench decoder.
// Depends on qdec_acc_pkg and the core RTL only.

module tb_top;
    import qdec_acc_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD  = 120;
    localparam int SETTLE     = 4;
    localparam int WALK_LEN   = 30;
    localparam int RUN_STEPS  = 20;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // enc_a, enc_b, now_ms[31:0], zero pad
    logic        s_axis_tuser  = 1'b0; // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // position[31:0], moved_by[7:0], delta[15:0]
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = '0;
    logic [15:0] cfg_wdata     = '0;

    // stimulus control, raised once at a clock edge
    logic        calm    = 1'b0;
    logic        hold_go = 1'b0;

    item_t       item_queue[$];
    result_t     predicted_results[$];
    int          fail_count = 0;

    // decoder state as the bench sees it
    cfg_t        cfg_model;
    logic [1:0]  pair_prev;
    logic [31:0] last_step_ms;
    logic [31:0] pos_acc;
    logic [31:0] pos_mark;

    // timestamp cursor used to build step sequences
    logic [31:0] t_cursor = 32'd0;

    quadrature_decoder_accel_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // expected result of one item; advances the bench decoder state
    function automatic result_t decode_item(input item_t it);
        result_t            r;
        logic [1:0]         pair;
        logic [31:0]        gap;
        logic [31:0]        full;
        logic [31:0]        half;
        logic [31:0]        scale;
        logic [31:0]        step;
        logic signed [31:0] diff;
        r = '0;
        if (it.mode == MODE_SAMPLE)
        begin
            pair = {it.enc_b, it.enc_a};
            step = 32'd0;
            if (pair != pair_prev)
            begin
                // only a move out of both-low counts
                if (pair_prev == AB_BOTH_LOW && (pair == AB_B_ONLY || pair == AB_A_ONLY))
                begin
                    full  = (cfg_model.accel_factor == '0) ? 32'd1
                                                           : {25'd0, cfg_model.accel_factor};
                    half  = full / 32'd2;
                    if (half == 32'd0)
                        half = 32'd1;
                    gap   = it.now_ms - last_step_ms;
                    scale = 32'd1;
                    // slow window first, fast window only inside it
                    if (gap < {16'd0, cfg_model.slow_window_ms})
                        scale = (gap < {16'd0, cfg_model.fast_window_ms}) ? full : half;
                    step         = (pair == AB_B_ONLY) ? scale : (32'd0 - scale);
                    pos_acc      = pos_acc + step;
                    last_step_ms = it.now_ms;
                end
                pair_prev = pair;
            end
            r.moved_by = step[7:0];
        end
        else
        begin
            // change since the last take, saturated to 16 bits
            diff = pos_acc - pos_mark;
            if (diff > 32'sd32767)
                r.delta = 16'sh7FFF;
            else if (diff < -32'sd32768)
                r.delta = 16'sh8000;
            else
                r.delta = diff[15:0];
            pos_mark = pos_acc;
        end
        r.position = pos_acc;
        return r;
    endfunction

    function automatic void push_item(input logic mode, input logic a, input logic b,
                                      input logic [31:0] t);
        item_t it;
        it.mode   = mode;
        it.enc_a  = a;
        it.enc_b  = b;
        it.now_ms = t;
        item_queue.push_back(it);
    endfunction

    // step interval aimed at the window regions and their edges
    function automatic logic [31:0] pick_gap();
        logic [31:0] fast;
        logic [31:0] slow;
        fast = {16'd0, cfg_model.fast_window_ms};
        slow = {16'd0, cfg_model.slow_window_ms};
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, fast);
            1:       return $urandom_range(fast, slow);
            2:       return $urandom_range(slow, slow + 200);
            3:
            begin
                case ($urandom_range(0, 3))
                    0:       return fast - 32'd1;
                    1:       return fast;
                    2:       return slow - 32'd1;
                    default: return slow;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // well-formed step: both low, then one line high after the given interval
    task automatic add_step(input logic up, input logic [31:0] gap);
        push_item(MODE_SAMPLE, 1'b0, 1'b0, t_cursor + $urandom_range(0, 3));
        t_cursor = t_cursor + gap;
        push_item(MODE_SAMPLE, ~up, up, t_cursor);
    endtask

    // mostly clean steps, with takes and random samples mixed in
    task automatic add_walk(input int n);
        int k;
        int r;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                push_item(MODE_TAKE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom());
            else if (r < 22)
                push_item(MODE_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 3) == 0) ? $urandom()
                                                      : t_cursor + $urandom_range(0, 100));
            else
                add_step(1'($urandom_range(0, 1)), pick_gap());
        end
    endtask

    // run in one direction, then a take, for a large delta
    task automatic add_run(input logic up, input int steps);
        int k;
        for (k = 0; k < steps; k++)
            add_step(up, $urandom_range(0, 30));
        push_item(MODE_TAKE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [6:0] factor, input logic [15:0] fast,
                              input logic [15:0] slow);
        write_reg(REG_ACCEL_FACTOR, {9'd0, factor});
        write_reg(REG_FAST_WINDOW, fast);
        write_reg(REG_SLOW_WINDOW, slow);
        cfg_model.accel_factor   = factor;
        cfg_model.fast_window_ms = fast;
        cfg_model.slow_window_ms = slow;
    endtask

    // wait until every item is sent and every result has come back
    task automatic settle();
        do
            @(negedge clk);
        while (item_queue.size() != 0 || s_axis_tvalid || predicted_results.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // input driver: one transaction per pending item, random idle bursts
    item_t item_on_bus;
    int    send_gap;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predicted_results.push_back(decode_item(item_on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (item_queue.size() > 0)
                begin
                    item_on_bus = item_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= item_on_bus.mode;
                    s_axis_tdata  <= {6'd0, item_on_bus.now_ms,
                                      item_on_bus.enc_b, item_on_bus.enc_a};
                    if (!calm && $urandom_range(0, 11) == 0)
                        send_gap = $urandom_range(1, 17);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor and receiver stalls
    result_t got;
    result_t want;
    int      stall_left;
    int      hold_left;
    logic    hold_started;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left   = 0;
            hold_left    = 0;
            hold_started = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata);
                if (predicted_results.size() == 0)
                begin
                    $error("output transaction with nothing expected: position %0d",
                           got.position);
                    fail_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.position !== want.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               want.position, got.position);
                        fail_count++;
                    end
                    if (got.moved_by !== want.moved_by)
                    begin
                        $error("moved_by: expected %0d, actual %0d",
                               want.moved_by, got.moved_by);
                        fail_count++;
                    end
                    if (got.delta !== want.delta)
                    begin
                        $error("delta: expected %0d, actual %0d", want.delta, got.delta);
                        fail_count++;
                    end
                end
            end

            // one long hold-off so the core backs up into its input
            if (hold_go && !hold_started)
            begin
                hold_started = 1'b1;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    int idle_cycles;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles = 0;
        end
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        int ph;
        cfg_model.accel_factor   = FACTOR_RST;
        cfg_model.fast_window_ms = FAST_WINDOW_RST;
        cfg_model.slow_window_ms = SLOW_WINDOW_RST;
        pair_prev    = AB_IDLE_HIGH;
        last_step_ms = 32'd0;
        pos_acc      = 32'd0;
        pos_mark     = 32'd0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults: slow step, then a medium step where half the factor is zero
        push_item(MODE_TAKE,   1'b0, 1'b0, 32'd0);
        push_item(MODE_SAMPLE, 1'b0, 1'b0, 32'd100);
        push_item(MODE_SAMPLE, 1'b1, 1'b0, 32'd110);
        push_item(MODE_SAMPLE, 1'b0, 1'b0, 32'd120);
        push_item(MODE_SAMPLE, 1'b0, 1'b1, 32'd170);
        push_item(MODE_TAKE,   1'b1, 1'b1, 32'hFFFF_FFFF);
        settle();

        // full factor, timestamp wrap, medium step, moves that do not leave both-low
        set_config(7'd127, 16'd40, 16'd80);
        push_item(MODE_TAKE,   1'b1, 1'b1, 32'hFFFF_FFFF);
        push_item(MODE_SAMPLE, 1'b0, 1'b0, 32'hFFFF_FFF0);
        push_item(MODE_SAMPLE, 1'b0, 1'b1, 32'hFFFF_FFF8);
        push_item(MODE_SAMPLE, 1'b0, 1'b0, 32'd2);
        push_item(MODE_SAMPLE, 1'b0, 1'b1, 32'd10);
        push_item(MODE_SAMPLE, 1'b0, 1'b0, 32'd20);
        push_item(MODE_SAMPLE, 1'b1, 1'b0, 32'd60);
        push_item(MODE_SAMPLE, 1'b1, 1'b1, 32'd70);
        push_item(MODE_SAMPLE, 1'b0, 1'b1, 32'd75);
        push_item(MODE_TAKE,   1'b0, 1'b0, 32'd0);
        settle();

        // zero factor behaves as one
        set_config(7'd0, 16'hFFFF, 16'hFFFF);
        push_item(MODE_SAMPLE, 1'b0, 1'b0, 32'd90);
        push_item(MODE_SAMPLE, 1'b0, 1'b1, 32'd100);
        settle();

        // fast window above slow window: steps between the two are not scaled
        set_config(7'd10, 16'd200, 16'd50);
        push_item(MODE_SAMPLE, 1'b0, 1'b0, 32'd1000);
        push_item(MODE_SAMPLE, 1'b1, 1'b0, 32'd1100);
        push_item(MODE_SAMPLE, 1'b0, 1'b0, 32'd1110);
        push_item(MODE_SAMPLE, 1'b0, 1'b1, 32'd1200);
        push_item(MODE_SAMPLE, 1'b0, 1'b0, 32'd1210);
        push_item(MODE_SAMPLE, 1'b0, 1'b1, 32'd1230);
        push_item(MODE_TAKE,   1'b1, 1'b0, 32'd0);
        settle();

        // random phases over several settings, with one-way runs near the end
        t_cursor = $urandom();
        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                1:       set_config(7'd1, 16'd0, 16'd0);
                2:       set_config(7'd127, 16'hFFFF, 16'hFFFF);
                3:       set_config(7'd0, 16'hFFFF, 16'd0);
                5:       set_config(7'd127, 16'hFFFF, 16'hFFFF);
                default: set_config(7'($urandom_range(0, 127)), 16'($urandom_range(0, 300)),
                                    16'($urandom_range(0, 300)));
            endcase
            if (ph == 0)
            begin
                @(posedge clk);
                hold_go <= 1'b1;
            end
            if (ph == 6)
            begin
                @(posedge clk);
                calm <= 1'b1;
            end
            if (ph == 5)
            begin
                add_run(1'b1, RUN_STEPS);
                add_run(1'b0, RUN_STEPS);
            end
            else
            begin
                add_walk(WALK_LEN);
            end
            settle();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
